// ----- rtl/core/ltca_pkg.sv -----
// ----------------------------------------------------------------------------
// ltca_pkg
// Shared types, constants and helpers for the lava texture cell automaton.
// ----------------------------------------------------------------------------
package ltca_pkg;

    localparam int TILE_SIZE_DEF = 16;

    localparam logic [15:0] THRESHOLD_RESET = 16'd328;

    // Q4.12 constants
    localparam logic signed [15:0] SPARK_DECAY = 16'sd246;   // 0.06
    localparam logic signed [15:0] SPARK_RELIT = 16'sd6144;  // 1.5
    localparam logic signed [7:0]  GLOW_GAIN   = 8'sd41;     // 0.01
    localparam logic signed [13:0] GLOW_MIX    = 14'sd3277;  // 0.8

    // floor(u / 10) = (u * DIV10_MUL) >> DIV10_SHIFT for u < 2^20
    localparam logic [19:0] DIV10_MUL   = 20'd838861;
    localparam int          DIV10_SHIFT = 23;
    // bias making the rounded sum non-negative; a multiple of ten plus five
    localparam logic [19:0] DIV10_BIAS  = 20'd300005;
    localparam logic signed [17:0] DIV10_UNBIAS = 18'sd30000;

    localparam logic [3:0] LAST_READ_STEP = 4'd8;
    localparam logic [3:0] LAST_STEP      = 4'd9;
    localparam logic [3:0] GLOW_STEPS     = 4'd4;

    typedef struct packed {
        logic       clear;
        logic       capture;
        logic       read;
        logic [3:0] step;
        logic       calc_a;
        logic       calc_b;
        logic       col1;
        logic       col2;
        logic       load;
    } cmd_t;

    typedef struct packed {
        logic clear_done;
        logic out_free;
    } stat_t;

    typedef enum logic [7:0] {
        S_CLEAR  = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_READ   = 8'b0000_0100,
        S_CALC_A = 8'b0000_1000,
        S_CALC_B = 8'b0001_0000,
        S_COL1   = 8'b0010_0000,
        S_COL2   = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } state_t;

    // trunc(1.2*sin(2*pi*i/16))
    function automatic logic signed [1:0] skew(input logic [3:0] i);
        logic signed [1:0] r;
        case (i)
            4'd3, 4'd4, 4'd5:    r = 2'sd1;
            4'd11, 4'd12, 4'd13: r = -2'sd1;
            default:             r = 2'sd0;
        endcase
        return r;
    endfunction

    // 3x3 tap offsets for read step 0..8
    function automatic logic signed [1:0] tap_dx(input logic [3:0] s);
        logic signed [1:0] r;
        case (s)
            4'd0, 4'd1, 4'd2: r = -2'sd1;
            4'd3, 4'd4, 4'd5: r = 2'sd0;
            default:          r = 2'sd1;
        endcase
        return r;
    endfunction

    function automatic logic signed [1:0] tap_dy(input logic [3:0] s);
        logic signed [1:0] r;
        case (s)
            4'd0, 4'd3, 4'd6: r = -2'sd1;
            4'd1, 4'd4, 4'd7: r = 2'sd0;
            default:          r = 2'sd1;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/core/lava_texture_cell_automaton.sv -----
// ----------------------------------------------------------------------------
// lava_texture_cell_automaton
// Animated wrapping lava heat grid, one cell and one RGB pixel per transfer.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over all TILE_SIZE*TILE_SIZE
// cells (256 at the default size) that zeroes the heat, glow and spark
// memories; in_ready stays low until it ends, while threshold writes are
// taken at any time. Each accepted draw then passes from input transfer to
// the output register through nine heat reads on the single port of the
// read bank (the four glow reads and the spark read overlap the first
// ones), the read latency, two arithmetic steps, two color steps and the
// output load. One cell is worked at a time; the next draw is accepted as
// soon as the previous result is loaded, even if it has not been taken.
// ----------------------------------------------------------------------------
module lava_texture_cell_automaton
#(
    parameter int TILE_SIZE = ltca_pkg::TILE_SIZE_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] random_draw,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  pixel_index,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue,
    output logic        last_of_frame
);

    ltca_pkg::cmd_t  cmd;
    ltca_pkg::stat_t stat;

    // threshold register takes a transfer in any cycle
    assign cfg_ready = 1'b1;

    ltca_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ltca_datapath #(.TILE_SIZE(TILE_SIZE)) u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .cfg_valid     (cfg_valid),
        .cfg_data      (cfg_data),
        .random_draw   (random_draw),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .pixel_index   (pixel_index),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .last_of_frame (last_of_frame)
    );

endmodule

// ----- rtl/core/ltca_ctrl.sv -----
// ----------------------------------------------------------------------------
// ltca_ctrl
// Sequencer: clearing pass, grid reads, arithmetic and color steps.
// ----------------------------------------------------------------------------
module ltca_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  ltca_pkg::stat_t stat,
    output ltca_pkg::cmd_t  cmd
);

    ltca_pkg::state_t state_reg, state_next;
    logic [3:0] step_reg, step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ltca_pkg::S_CLEAR;
            step_reg  <= 4'd0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    assign in_ready = (state_reg == ltca_pkg::S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            ltca_pkg::S_CLEAR:
            begin
                if (stat.clear_done)
                    state_next = ltca_pkg::S_IDLE;
            end
            ltca_pkg::S_IDLE:
            begin
                step_next = 4'd0;
                if (in_valid)
                    state_next = ltca_pkg::S_READ;
            end
            ltca_pkg::S_READ:
            begin
                step_next = step_reg + 4'd1;
                if (step_reg == ltca_pkg::LAST_STEP)
                    state_next = ltca_pkg::S_CALC_A;
            end
            ltca_pkg::S_CALC_A: state_next = ltca_pkg::S_CALC_B;
            ltca_pkg::S_CALC_B: state_next = ltca_pkg::S_COL1;
            ltca_pkg::S_COL1:   state_next = ltca_pkg::S_COL2;
            ltca_pkg::S_COL2:   state_next = ltca_pkg::S_DONE;
            ltca_pkg::S_DONE:
            begin
                if (stat.out_free)
                    state_next = ltca_pkg::S_IDLE;
            end
            default: state_next = ltca_pkg::S_CLEAR;
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        cmd.step    = step_reg;
        cmd.clear   = (state_reg == ltca_pkg::S_CLEAR);
        cmd.capture = (state_reg == ltca_pkg::S_IDLE) && in_valid;
        cmd.read    = (state_reg == ltca_pkg::S_READ);
        cmd.calc_a  = (state_reg == ltca_pkg::S_CALC_A);
        cmd.calc_b  = (state_reg == ltca_pkg::S_CALC_B);
        cmd.col1    = (state_reg == ltca_pkg::S_COL1);
        cmd.col2    = (state_reg == ltca_pkg::S_COL2);
        cmd.load    = (state_reg == ltca_pkg::S_DONE) && stat.out_free;
    end

endmodule

// ----- rtl/core/ltca_datapath.sv -----
// ----------------------------------------------------------------------------
// ltca_datapath
// Grid memories, accumulators, heat/glow/spark update and color pipeline.
// ----------------------------------------------------------------------------
module ltca_datapath
#(
    parameter int TILE_SIZE = ltca_pkg::TILE_SIZE_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  ltca_pkg::cmd_t  cmd,
    output ltca_pkg::stat_t stat,
    input  logic            cfg_valid,
    input  logic [15:0]     cfg_data,
    input  logic [15:0]     random_draw,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [7:0]      pixel_index,
    output logic [7:0]      red,
    output logic [7:0]      green,
    output logic [7:0]      blue,
    output logic            last_of_frame
);

    localparam int LOG   = $clog2(TILE_SIZE);
    localparam int AW    = 2 * LOG;
    localparam int CELLS = TILE_SIZE * TILE_SIZE;

    // control registers
    logic [15:0]   thr_reg;
    logic [AW-1:0] pos_reg;
    logic          bank_reg;
    logic [AW-1:0] clr_reg;
    logic          out_valid_reg;
    logic          acc_en_reg;
    logic [3:0]    acc_step_reg;

    // payload registers
    logic [15:0]        draw_reg;
    logic signed [19:0] sum_reg;
    logic signed [17:0] gsum_reg;
    logic signed [15:0] glow_self_reg;
    logic signed [15:0] spark_self_reg;
    logic [39:0]        quo_reg;
    logic signed [30:0] gmix_reg;
    logic signed [22:0] spk_reg;
    logic [12:0]        c_reg;
    logic [24:0]        c2_reg;
    logic [48:0]        c4_reg;
    logic [7:0]         red_reg;
    logic [7:0]         green_reg;
    logic [7:0]         pix_reg, red_out_reg, green_out_reg, blue_out_reg;
    logic               last_out_reg;

    logic signed [15:0] heat0 [CELLS];
    logic signed [15:0] heat1 [CELLS];
    logic signed [15:0] glow_mem [CELLS];
    logic signed [15:0] spark_mem [CELLS];
    logic signed [15:0] heat0_rd_reg, heat1_rd_reg, glow_rd_reg, spark_rd_reg;

    logic [LOG-1:0] x, y;
    logic [AW-1:0]  idx;
    logic           last_cell;
    assign x         = pos_reg[AW-1:LOG];
    assign y         = pos_reg[LOG-1:0];
    assign idx       = {y, x};
    assign last_cell = (pos_reg == AW'(CELLS - 1));

    // read addresses
    logic [LOG-1:0] hx, hy, gx, gy;
    logic [AW-1:0]  heat_raddr, glow_raddr;
    always_comb
    begin
        hx = x + LOG'(ltca_pkg::tap_dx(cmd.step)) + LOG'(ltca_pkg::skew(y[3:0]));
        hy = y + LOG'(ltca_pkg::tap_dy(cmd.step)) + LOG'(ltca_pkg::skew(x[3:0]));
        gx = x + LOG'(cmd.step == 4'd1 || cmd.step == 4'd2);
        gy = y + LOG'(cmd.step == 4'd2 || cmd.step == 4'd3);
        heat_raddr = {hy, hx};
        glow_raddr = {gy, gx};
    end

    // update arithmetic
    logic signed [17:0] quot;
    logic signed [31:0] gmix_r;
    logic signed [19:0] heat_wide;
    logic signed [15:0] heat_new;
    logic signed [23:0] spk_r;
    logic signed [17:0] glow_wide;
    logic signed [15:0] glow_new;
    logic signed [16:0] spark_wide;
    logic signed [15:0] spark_new;
    logic signed [16:0] heat2;
    logic [12:0]        c_next;
    logic [19:0]        div_in;
    always_comb
    begin
        div_in    = 20'(sum_reg) + ltca_pkg::DIV10_BIAS;
        quot      = $signed({1'b0, quo_reg[39:ltca_pkg::DIV10_SHIFT]}) - ltca_pkg::DIV10_UNBIAS;
        gmix_r    = 32'(gmix_reg) + 32'sd8192;
        heat_wide = 20'(quot) + 20'(gmix_r >>> 14);
        if (heat_wide > 20'sd32767)
            heat_new = 16'sd32767;
        else if (heat_wide < -20'sd32768)
            heat_new = -16'sd32768;
        else
            heat_new = heat_wide[15:0];

        spk_r     = 24'(spk_reg) + 24'sd2048;
        glow_wide = 18'(glow_self_reg) + 18'(spk_r >>> 12);
        if (glow_wide > 18'sd32767)
            glow_new = 16'sd32767;
        else if (glow_wide < 18'sd0)
            glow_new = 16'sd0;
        else
            glow_new = glow_wide[15:0];

        spark_wide = 17'(spark_self_reg) - 17'(ltca_pkg::SPARK_DECAY);
        if (draw_reg < thr_reg)
            spark_new = ltca_pkg::SPARK_RELIT;
        else if (spark_wide < -17'sd32768)
            spark_new = -16'sd32768;
        else
            spark_new = spark_wide[15:0];

        heat2 = 17'(heat_new) <<< 1;
        if (heat2 > 17'sd4096)
            c_next = 13'd4096;
        else if (heat2 < 17'sd0)
            c_next = 13'd0;
        else
            c_next = heat2[12:0];
    end

    // memories: one address per cycle each
    logic [AW-1:0] haddr, gaddr, saddr;
    logic          h0_we, h1_we, g_we;
    assign haddr = cmd.clear ? clr_reg : (cmd.calc_b ? idx : heat_raddr);
    assign gaddr = cmd.clear ? clr_reg : (cmd.calc_b ? idx : glow_raddr);
    assign saddr = cmd.clear ? clr_reg : idx;
    assign h0_we = cmd.clear || (cmd.calc_b && bank_reg);
    assign h1_we = cmd.clear || (cmd.calc_b && !bank_reg);
    assign g_we  = cmd.clear || cmd.calc_b;

    always_ff @(posedge clk)
    begin
        if (h0_we)
            heat0[haddr] <= cmd.clear ? 16'sd0 : heat_new;
        heat0_rd_reg <= heat0[haddr];
    end

    always_ff @(posedge clk)
    begin
        if (h1_we)
            heat1[haddr] <= cmd.clear ? 16'sd0 : heat_new;
        heat1_rd_reg <= heat1[haddr];
    end

    always_ff @(posedge clk)
    begin
        if (g_we)
            glow_mem[gaddr] <= cmd.clear ? 16'sd0 : glow_new;
        glow_rd_reg <= glow_mem[gaddr];
    end

    always_ff @(posedge clk)
    begin
        if (g_we)
            spark_mem[saddr] <= cmd.clear ? 16'sd0 : spark_new;
        spark_rd_reg <= spark_mem[saddr];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg       <= ltca_pkg::THRESHOLD_RESET;
            pos_reg       <= '0;
            bank_reg      <= 1'b0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            acc_en_reg    <= 1'b0;
            acc_step_reg  <= 4'd0;
        end
        else
        begin
            if (cfg_valid)
                thr_reg <= cfg_data;
            if (cmd.clear)
                clr_reg <= clr_reg + AW'(1);
            acc_en_reg   <= cmd.read && (cmd.step <= ltca_pkg::LAST_READ_STEP);
            acc_step_reg <= cmd.step;
            if (cmd.load)
            begin
                out_valid_reg <= 1'b1;
                pos_reg       <= last_cell ? '0 : pos_reg + AW'(1);
                if (last_cell)
                    bank_reg <= !bank_reg;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            draw_reg <= random_draw;
            sum_reg  <= '0;
            gsum_reg <= '0;
        end
        if (acc_en_reg)
        begin
            sum_reg <= sum_reg + 20'(bank_reg ? heat1_rd_reg : heat0_rd_reg);
            if (acc_step_reg < ltca_pkg::GLOW_STEPS)
                gsum_reg <= gsum_reg + 18'(glow_rd_reg);
            if (acc_step_reg == 4'd0)
            begin
                glow_self_reg  <= glow_rd_reg;
                spark_self_reg <= spark_rd_reg;
            end
        end
        if (cmd.calc_a)
        begin
            quo_reg  <= 40'(div_in) * 40'(ltca_pkg::DIV10_MUL);
            gmix_reg <= 31'(gsum_reg) * 31'(ltca_pkg::GLOW_MIX);
            spk_reg  <= 23'(spark_self_reg) * 23'(ltca_pkg::GLOW_GAIN);
        end
        if (cmd.calc_b)
            c_reg <= c_next;
        if (cmd.col1)
        begin
            c2_reg  <= 25'(c_reg) * 25'(c_reg);
            red_reg <= 8'(8'd155 + 8'((20'(c_reg) * 20'd100) >> 12));
        end
        if (cmd.col2)
        begin
            c4_reg    <= 49'(c2_reg) * 49'(c2_reg);
            green_reg <= 8'((33'(c2_reg) * 33'd255) >> 24);
        end
        if (cmd.load)
        begin
            pix_reg       <= idx[7:0];
            red_out_reg   <= red_reg;
            green_out_reg <= green_reg;
            blue_out_reg  <= c4_reg[48:41];
            last_out_reg  <= last_cell;
        end
    end

    assign stat.clear_done = (clr_reg == AW'(CELLS - 1));
    assign stat.out_free   = !out_valid_reg || out_ready;

    assign out_valid     = out_valid_reg;
    assign pixel_index   = pix_reg;
    assign red           = red_out_reg;
    assign green         = green_out_reg;
    assign blue          = blue_out_reg;
    assign last_of_frame = last_out_reg;

endmodule

// ----- rtl/core/ltca_checker.sv -----
// ----------------------------------------------------------------------------
// ltca_checker
// Port-level checks, bound to the top level.
// ----------------------------------------------------------------------------
module ltca_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] pixel_index,
    input logic [7:0] red,
    input logic [7:0] blue,
    input logic       last_of_frame
);

    // one cell in flight: no back-to-back input transfers
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input transfer in consecutive cycles");

    // frame end is always the bottom-right cell
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_of_frame |-> pixel_index == 8'hFF)
        else $error("frame end on wrong cell");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> red >= 8'd155 && blue <= 8'd128)
        else $error("color out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pixel_index))
        else $error("stalled result changed");

endmodule

bind lava_texture_cell_automaton ltca_checker u_ltca_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .pixel_index   (pixel_index),
    .red           (red),
    .blue          (blue),
    .last_of_frame (last_of_frame)
);
